// ----- hdl/rsie_pkg.sv -----
// shared types and constants of the instruction executor
`default_nettype none

package rsie_pkg;

    localparam int MEM_WORDS = 65536;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int MEM_BYTES = MEM_WORDS * 4;
    localparam int REGS      = 32;
    localparam int RF_AW     = $clog2(REGS);
    localparam int CLR_WORDS = (MEM_WORDS > REGS) ? MEM_WORDS : REGS;
    localparam int CLR_AW    = $clog2(CLR_WORDS);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);

    typedef enum logic [3:0] {
        FN_ADD  = 4'd0,
        FN_SUB  = 4'd1,
        FN_MUL  = 4'd2,
        FN_SLT  = 4'd3,
        FN_ADDI = 4'd4,
        FN_BEQ  = 4'd5,
        FN_BNE  = 4'd6,
        FN_J    = 4'd7,
        FN_LW   = 4'd8,
        FN_SW   = 4'd9
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REG_ZERO  = 2'd1,
        ST_BAD_LABEL = 2'd2,
        ST_BAD_ADDR  = 2'd3
    } status_t;

    typedef struct packed {
        logic [3:0]         func;
        logic [4:0]         reg_first;
        logic [4:0]         reg_second;
        logic [4:0]         reg_third;
        logic signed [31:0] imm_value;
        logic               has_base;
        logic [15:0]        target;
        logic               target_valid;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        next_pc;
        logic               reg_written;
        logic signed [31:0] write_value;
        logic               mem_changed;
    } out_item_t;

    typedef struct packed {
        logic             en;
        logic [RF_AW-1:0] addr;
        logic [31:0]      data;
    } rf_wr_t;

endpackage

`default_nettype wire

// ----- hdl/rsie_regfile.sv -----
// register file: two registered read ports, one write port
`default_nettype none

module rsie_regfile import rsie_pkg::*; (
    input  logic             aclk,
    input  logic [RF_AW-1:0] rd_addr_a,
    input  logic [RF_AW-1:0] rd_addr_b,
    output logic [31:0]      rd_data_a,
    output logic [31:0]      rd_data_b,
    input  rf_wr_t           wr
);

    logic [31:0] rf_mem [REGS];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            rf_mem[wr.addr] <= wr.data;
        end
        rd_data_a <= rf_mem[rd_addr_a];
        rd_data_b <= rf_mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// ----- hdl/rsie_out_fifo.sv -----
// result queue between the execute pipeline and the result channel
`default_nettype none

module rsie_out_fifo import rsie_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  out_item_t         push_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    output logic [OUT_AW:0]   count
);

    out_item_t           buf_mem [OUT_DEPTH];
    logic [OUT_AW-1:0]   wr_ptr_reg;
    logic [OUT_AW-1:0]   rd_ptr_reg;
    logic [OUT_AW:0]     count_reg;
    logic                pop;

    assign m_valid = (count_reg != '0);
    assign m_data  = buf_mem[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    assign count   = count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/risc_subset_instruction_executor.sv -----
// top level: decoded-instruction executor with register file and data memory
`default_nettype none

// Executes one decoded instruction per item and returns one result item for each.
// Throughput is one item per clock while s_ready stays high: an accepted item issues its
// register file read at the accepting edge; stage 1 computes, checks and updates the program
// counter and issues the data memory read; stage 2 writes back the register file and data
// memory and writes its result into a four-entry output queue, from which it shows on m_valid.
// Register and memory hazards between neighboring items are resolved by forwarding, so no
// instruction mix slows the block. s_ready drops only while the output queue plus the
// items in flight would exceed four entries. After reset a clearing pass zeroes the data
// memory and the register file, one word per cycle; no item is accepted during it, while
// configuration writes are taken.

module risc_subset_instruction_executor import rsie_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam logic [31:0] MEM_LIMIT = 32'(MEM_BYTES);

    // control and configuration
    logic              clearing_reg;
    logic [CLR_AW-1:0] clr_cnt_reg;
    logic [15:0]       code_words_reg;
    logic [15:0]       pc_reg;
    logic              accept;
    logic [OUT_AW:0]   fifo_count;
    logic [OUT_AW+1:0] in_use;

    // stage 1
    logic              s1_valid_reg;
    in_item_t          s1_item_reg;
    logic [RF_AW-1:0]  rd_addr_b;
    logic [RF_AW-1:0]  s1_addr_b;
    logic [31:0]       rf_q_a;
    logic [31:0]       rf_q_b;
    logic [31:0]       op_a;
    logic [31:0]       op_b;
    logic [31:0]       sum_ai;
    logic [31:0]       prod;
    logic [31:0]       alu_res;
    logic [31:0]       mem_addr;
    logic              addr_ok;
    status_t           s1_status;
    logic [15:0]       s1_npc;
    logic              s1_we;
    logic              s1_is_lw;
    logic              s1_is_sw;
    logic [31:0]       s1_val;
    logic [MEM_AW-1:0] s1_idx;

    // stage 2
    logic              s2_valid_reg;
    status_t           s2_status_reg;
    logic [15:0]       s2_npc_reg;
    logic              s2_rd_we_reg;
    logic [RF_AW-1:0]  s2_rd_reg;
    logic              s2_is_lw_reg;
    logic              s2_is_sw_reg;
    logic [31:0]       s2_val_reg;
    logic [MEM_AW-1:0] s2_idx_reg;
    logic [31:0]       dmem_q_reg;
    logic [31:0]       mem_old;
    logic [31:0]       s2_wval;
    out_item_t         s2_out;

    // last writes, for reads issued at the same edge
    logic              rfl_valid_reg;
    logic [RF_AW-1:0]  rfl_addr_reg;
    logic [31:0]       rfl_data_reg;
    logic              ml_valid_reg;
    logic [MEM_AW-1:0] ml_idx_reg;
    logic [31:0]       ml_data_reg;

    logic [31:0]       dmem [MEM_WORDS];
    rf_wr_t            rf_wr;

    assign cfg_ready = 1'b1;
    assign in_use    = (OUT_AW+2)'(fifo_count) + (OUT_AW+2)'(s1_valid_reg)
                     + (OUT_AW+2)'(s2_valid_reg);
    assign s_ready   = !clearing_reg && (in_use < (OUT_AW+2)'(OUT_DEPTH));
    assign accept    = s_valid && s_ready;

    // port b serves reg_third for register-register ops, reg_first otherwise
    assign rd_addr_b = (s_data.func <= FN_SLT) ? s_data.reg_third : s_data.reg_first;
    assign s1_addr_b = (s1_item_reg.func <= FN_SLT) ? s1_item_reg.reg_third
                                                    : s1_item_reg.reg_first;

    rsie_regfile u_regfile (
        .aclk      (aclk),
        .rd_addr_a (s_data.reg_second),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rf_q_a),
        .rd_data_b (rf_q_b),
        .wr        (rf_wr)
    );

    always_comb begin
        rf_wr.en   = clearing_reg ? 1'b1 : s2_rd_we_reg;
        rf_wr.addr = clearing_reg ? clr_cnt_reg[RF_AW-1:0] : s2_rd_reg;
        rf_wr.data = clearing_reg ? 32'd0 : s2_wval;
    end

    // operand forwarding: stage 2 write first, then the write of the edge of the read
    always_comb begin
        op_a = rf_q_a;
        if (s2_rd_we_reg && s2_rd_reg == s1_item_reg.reg_second) begin
            op_a = s2_wval;
        end else if (rfl_valid_reg && rfl_addr_reg == s1_item_reg.reg_second) begin
            op_a = rfl_data_reg;
        end
        op_b = rf_q_b;
        if (s2_rd_we_reg && s2_rd_reg == s1_addr_b) begin
            op_b = s2_wval;
        end else if (rfl_valid_reg && rfl_addr_reg == s1_addr_b) begin
            op_b = rfl_data_reg;
        end
    end

    always_comb begin
        sum_ai   = op_a + s1_item_reg.imm_value;
        prod     = op_a * op_b;
        mem_addr = s1_item_reg.has_base ? sum_ai : s1_item_reg.imm_value;
        addr_ok  = (mem_addr[1:0] == 2'b00) && !mem_addr[31]
                && (mem_addr >= {14'd0, code_words_reg, 2'b00})
                && (mem_addr < MEM_LIMIT);
        s1_idx   = mem_addr[MEM_AW+1:2];

        case (s1_item_reg.func)
            FN_ADD:  alu_res = op_a + op_b;
            FN_SUB:  alu_res = op_a - op_b;
            FN_MUL:  alu_res = prod;
            FN_SLT:  alu_res = {31'd0, $signed(op_a) < $signed(op_b)};
            default: alu_res = sum_ai;
        endcase

        s1_status = ST_OK;
        s1_npc    = 16'(pc_reg + 16'd1);
        s1_we     = 1'b0;
        s1_is_lw  = 1'b0;
        s1_is_sw  = 1'b0;
        s1_val    = 32'd0;
        unique case (s1_item_reg.func) inside
            FN_ADD, FN_SUB, FN_MUL, FN_SLT, FN_ADDI: begin
                if (s1_item_reg.reg_first == '0) begin
                    s1_status = ST_REG_ZERO;
                end else begin
                    s1_we  = 1'b1;
                    s1_val = alu_res;
                end
            end
            FN_BEQ, FN_BNE, FN_J: begin
                if (!s1_item_reg.target_valid) begin
                    s1_status = ST_BAD_LABEL;
                end else if (s1_item_reg.func == FN_J
                          || (s1_item_reg.func == FN_BEQ && op_a == op_b)
                          || (s1_item_reg.func == FN_BNE && op_a != op_b)) begin
                    s1_npc = s1_item_reg.target;
                end
            end
            FN_LW: begin
                if (s1_item_reg.reg_first == '0) begin
                    s1_status = ST_REG_ZERO;
                end else if (!addr_ok) begin
                    s1_status = ST_BAD_ADDR;
                end else begin
                    s1_we    = 1'b1;
                    s1_is_lw = 1'b1;
                end
            end
            FN_SW: begin
                if (!addr_ok) begin
                    s1_status = ST_BAD_ADDR;
                end else begin
                    s1_is_sw = 1'b1;
                    s1_val   = op_b;
                end
            end
            default: begin
            end
        endcase
        if (s1_status != ST_OK) begin
            s1_npc = pc_reg;
        end
    end

    // a store of the previous item lands at the edge this item's read was issued
    assign mem_old = (ml_valid_reg && ml_idx_reg == s2_idx_reg) ? ml_data_reg : dmem_q_reg;
    assign s2_wval = s2_is_lw_reg ? mem_old : s2_val_reg;

    always_comb begin
        s2_out.status      = s2_status_reg;
        s2_out.next_pc     = s2_npc_reg;
        s2_out.reg_written = s2_rd_we_reg;
        s2_out.write_value = s2_wval;
        s2_out.mem_changed = s2_is_sw_reg && (mem_old != s2_val_reg);
    end

    rsie_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s2_valid_reg),
        .push_data (s2_out),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .count     (fifo_count)
    );

    // data memory
    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            if ({1'b0, clr_cnt_reg} < (CLR_AW+1)'(MEM_WORDS)) begin
                dmem[clr_cnt_reg[MEM_AW-1:0]] <= 32'd0;
            end
        end else if (s2_is_sw_reg) begin
            dmem[s2_idx_reg] <= s2_val_reg;
        end
        dmem_q_reg <= dmem[s1_idx];
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg <= s_data;
        end
        s2_status_reg <= s1_status;
        s2_npc_reg    <= s1_npc;
        s2_rd_reg     <= s1_item_reg.reg_first;
        s2_val_reg    <= s1_val;
        s2_idx_reg    <= s1_idx;
        rfl_addr_reg  <= s2_rd_reg;
        rfl_data_reg  <= s2_wval;
        ml_idx_reg    <= s2_idx_reg;
        ml_data_reg   <= s2_val_reg;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
            code_words_reg <= '0;
            pc_reg         <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s2_rd_we_reg   <= 1'b0;
            s2_is_lw_reg   <= 1'b0;
            s2_is_sw_reg   <= 1'b0;
            rfl_valid_reg  <= 1'b0;
            ml_valid_reg   <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_AW'(CLR_WORDS - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (cfg_valid && cfg_ready) begin
                code_words_reg <= cfg_data;
            end
            if (s1_valid_reg) begin
                pc_reg <= s1_npc;
            end
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            s2_rd_we_reg  <= s1_valid_reg && s1_we;
            s2_is_lw_reg  <= s1_valid_reg && s1_is_lw;
            s2_is_sw_reg  <= s1_valid_reg && s1_is_sw;
            rfl_valid_reg <= !clearing_reg && s2_rd_we_reg;
            ml_valid_reg  <= !clearing_reg && s2_is_sw_reg;
        end
    end

`ifndef SYNTHESIS
    a_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        in_use <= (OUT_AW+2)'(OUT_DEPTH))
        else $error("output queue credit exceeded");

    a_reg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        rf_wr.en && !clearing_reg |-> rf_wr.addr != '0)
        else $error("register zero written");

    a_err_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_status != ST_OK |=> pc_reg == $past(pc_reg))
        else $error("program counter moved on error");

    a_err_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && s2_status_reg != ST_OK
            |-> !s2_rd_we_reg && !s2_is_sw_reg && s2_val_reg == '0)
        else $error("state write on error");

    a_clear_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s1_valid_reg && !s2_valid_reg && fifo_count == '0)
        else $error("item in flight during clearing pass");
`endif

endmodule

`default_nettype wire
